### src/lbgs_pkg.sv
// shared types, constants and the life rule for the life board generation step block
`timescale 1ns / 1ps
`default_nettype none

package lbgs_pkg;

    // board geometry
    localparam int ROWS      = 64;
    localparam int COLS      = 128;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int ROW_CNT_W = $clog2(ROWS + 1);
    localparam int COL_CNT_W = $clog2(COLS + 1);

    // field widths
    localparam int OPCODE_W    = 2;
    localparam int ROW_IDX_W   = 6;
    localparam int COL_IDX_W   = 7;
    localparam int ACT_ROWS_W  = 7;
    localparam int ACT_COLS_W  = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 8'd1;

    localparam logic [ACT_ROWS_W-1:0] ACTIVE_ROWS_RST = 7'd48;
    localparam logic [ACT_COLS_W-1:0] ACTIVE_COLS_RST = 8'd128;

    // neighbor counts of the rule
    localparam logic [3:0] N_SURVIVE = 4'd2;
    localparam logic [3:0] N_BIRTH   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN_PRIME,
        ST_GEN_RUN,
        ST_CELL_RD,
        ST_CELL_OP
    } lbgs_state_t;

    typedef struct packed {
        logic capture;
        logic gen_prime;
        logic gen_step;
        logic cell_rd;
        logic cell_finish;
    } lbgs_cmd_t;

    typedef struct packed {
        logic gen_done;
        logic out_free;
    } lbgs_status_t;

    // next row from the old rows above, at and below it (b3/s23, no wrap)
    function automatic logic [COLS-1:0] life_row(
        input logic [COLS-1:0] up,
        input logic [COLS-1:0] mid,
        input logic [COLS-1:0] dn
    );
        logic [COLS-1:0] res;
        logic [3:0]      n;
        res = '0;
        for (int c = 0; c < COLS; c++) begin
            n = 4'(up[c]) + 4'(dn[c]);
            if (c > 0) begin
                n = n + 4'(up[c-1]) + 4'(mid[c-1]) + 4'(dn[c-1]);
            end
            if (c < COLS - 1) begin
                n = n + 4'(up[c+1]) + 4'(mid[c+1]) + 4'(dn[c+1]);
            end
            res[c] = (n == N_BIRTH) || (mid[c] && (n == N_SURVIVE));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/lbgs_ctrl.sv
// sequencer for cell access and generation sweeps
`timescale 1ns / 1ps
`default_nettype none

module lbgs_ctrl
    import lbgs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic [OPCODE_W-1:0] s_opcode,
    output logic                     s_ready,
    input  wire lbgs_status_t        status,
    output lbgs_cmd_t                cmd
);

    lbgs_state_t state_reg;
    lbgs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_STEP) ? ST_GEN_PRIME : ST_CELL_RD;
                end
            end
            ST_GEN_PRIME: state_next = ST_GEN_RUN;
            ST_GEN_RUN: begin
                if (status.gen_done) begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_CELL_RD: state_next = ST_CELL_OP;
            ST_CELL_OP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_GEN_PRIME: cmd.gen_prime = 1'b1;
            ST_GEN_RUN:   cmd.gen_step  = 1'b1;
            ST_CELL_RD:   cmd.cell_rd   = 1'b1;
            ST_CELL_OP:   cmd.cell_finish = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### src/lbgs_datapath.sv
// board memory, row window, life logic, config registers and result register
`timescale 1ns / 1ps
`default_nettype none

module lbgs_datapath
    import lbgs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lbgs_cmd_t             cmd,
    output lbgs_status_t               status,
    input  wire logic [OPCODE_W-1:0]   s_opcode,
    input  wire logic [ROW_IDX_W-1:0]  s_row_index,
    input  wire logic [COL_IDX_W-1:0]  s_col_index,
    input  wire logic                  s_write_alive,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_cell_alive,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rdata_reg;
    logic [ROW_AW-1:0] rd_addr_reg;
    logic [ROWS-1:0] row_valid_reg;

    logic [OPCODE_W-1:0]  op_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [COL_IDX_W-1:0] col_reg;
    logic                 wa_reg;

    logic [ACT_ROWS_W-1:0] active_rows_reg;
    logic [ACT_COLS_W-1:0] active_cols_reg;

    logic [COLS-1:0]      above_reg;
    logic [COLS-1:0]      mid_reg;
    logic [ROW_CNT_W-1:0] cnt_reg;

    logic m_valid_reg;
    logic m_alive_reg;

    logic [ROW_CNT_W-1:0] used_rows;
    logic [COL_CNT_W-1:0] used_cols;
    logic [COLS-1:0]      col_mask;
    logic [ROW_CNT_W-1:0] cnt_plus;
    logic [ROW_CNT_W-1:0] cnt_minus;
    logic [COLS-1:0]      incoming;
    logic [COLS-1:0]      new_row;
    logic [COLS-1:0]      cell_word;
    logic [COLS-1:0]      cell_word_mod;
    logic                 in_area;
    logic                 rd_en;
    logic [ROW_AW-1:0]    rd_addr;
    logic                 wr_en;
    logic [ROW_AW-1:0]    wr_addr;
    logic [COLS-1:0]      wr_data;

    // area in use, registers clamped to the board
    assign used_rows = (active_rows_reg > ACT_ROWS_W'(ROWS)) ? ROW_CNT_W'(ROWS)
                                                             : ROW_CNT_W'(active_rows_reg);
    assign used_cols = (active_cols_reg > ACT_COLS_W'(COLS)) ? COL_CNT_W'(COLS)
                                                             : COL_CNT_W'(active_cols_reg);

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            col_mask[c] = (COL_CNT_W'(c) < used_cols);
        end
    end

    assign cnt_plus  = cnt_reg + ROW_CNT_W'(1);
    assign cnt_minus = cnt_reg - ROW_CNT_W'(1);

    // old row arriving from memory, dead outside the area
    assign incoming = ((cnt_reg < ROW_CNT_W'(ROWS)) && row_valid_reg[rd_addr_reg]
                       && (ROW_CNT_W'(rd_addr_reg) < used_rows)) ? (rdata_reg & col_mask)
                                                                 : '0;
    assign new_row = (cnt_minus < used_rows) ? (life_row(above_reg, mid_reg, incoming) & col_mask)
                                             : '0;

    assign cell_word = row_valid_reg[rd_addr_reg] ? rdata_reg : '0;
    assign in_area   = (ROW_CNT_W'(row_reg) < used_rows) && (COL_CNT_W'(col_reg) < used_cols);

    always_comb begin
        cell_word_mod          = cell_word;
        cell_word_mod[col_reg] = wa_reg;
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.gen_prime) begin
            rd_en = 1'b1;
        end
        if (cmd.gen_step) begin
            rd_en   = (cnt_plus < ROW_CNT_W'(ROWS));
            rd_addr = cnt_plus[ROW_AW-1:0];
            wr_en   = (cnt_reg != '0);
            wr_addr = cnt_minus[ROW_AW-1:0];
            wr_data = new_row;
        end
        if (cmd.cell_rd) begin
            rd_en   = 1'b1;
            rd_addr = ROW_AW'(row_reg);
        end
        if (cmd.cell_finish && (op_reg == OP_WRITE) && in_area) begin
            wr_en   = 1'b1;
            wr_addr = ROW_AW'(row_reg);
            wr_data = cell_word_mod;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_opcode;
            row_reg <= s_row_index;
            col_reg <= s_col_index;
            wa_reg  <= s_write_alive;
        end
        if (cmd.gen_prime) begin
            mid_reg <= '0;
        end
        if (cmd.gen_step) begin
            above_reg <= mid_reg;
            mid_reg   <= incoming;
        end
        if (cmd.cell_finish) begin
            m_alive_reg <= in_area ? ((op_reg == OP_WRITE) ? wa_reg : cell_word[col_reg]) : 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg   <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            active_rows_reg <= ACTIVE_ROWS_RST;
            active_cols_reg <= ACTIVE_COLS_RST;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.gen_prime) begin
                cnt_reg <= '0;
            end else if (cmd.gen_step) begin
                cnt_reg <= cnt_plus;
            end
            if (cmd.cell_finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == REG_ACTIVE_ROWS) begin
                    active_rows_reg <= cfg_data[ACT_ROWS_W-1:0];
                end else if (cfg_index == REG_ACTIVE_COLS) begin
                    active_cols_reg <= cfg_data[ACT_COLS_W-1:0];
                end
            end
        end
    end

    assign status.gen_done = (cnt_reg == ROW_CNT_W'(ROWS));
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_cell_alive = m_alive_reg;
    assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

### src/life_board_generation_step.sv
// top level of the conway life board with single-cell access and generation step
// usage
//   s_*: one word per command; s_opcode selects write cell, advance one generation
//   or read cell (unused code reads); s_row_index and s_col_index address the cell,
//   s_write_alive is the value written
//   m_*: one word per command, m_cell_alive is the addressed cell after the command,
//   0 when the cell lies outside the active area
//   cfg_*: index 0 active_rows, index 1 active_cols, other indexes dropped;
//   cfg_ready is always high, write only while the block is idle
// timing
//   cell write or read: the row word is read, then the result registered;
//   generation step: a prime state and a sweep over all rows precede that read;
//   the sweep reads one row word a cycle and writes back the row before the one
//   arriving, with a three-row window holding the old neighbors
//   s_ready is high only while idle, so one command is in flight at a time
// reset: aresetn clears the row valid bits so the board reads dead, and loads
//   active_rows 48 and active_cols 128; no clearing sweep is needed
// stalls: a finished word waits in the output register; the next command is
//   taken meanwhile and holds in its last cycle until that register frees up
`timescale 1ns / 1ps
`default_nettype none

module life_board_generation_step
    import lbgs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command words
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OPCODE_W-1:0]   s_opcode,
    input  wire logic [ROW_IDX_W-1:0]  s_row_index,
    input  wire logic [COL_IDX_W-1:0]  s_col_index,
    input  wire logic                  s_write_alive,
    // result words
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_cell_alive,
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    lbgs_cmd_t    cmd;
    lbgs_status_t status;

    // sequencer: idle, generation sweep, cell read and finish
    lbgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // board memory, row window, life rule and output register
    lbgs_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_opcode      (s_opcode),
        .s_row_index   (s_row_index),
        .s_col_index   (s_col_index),
        .s_write_alive (s_write_alive),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cell_alive  (m_cell_alive),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

`default_nettype wire
